### src/lsh_pkg.sv
// Types, codes and mixing helpers shared by the level state hash blocks.
// No dependencies.
`default_nettype none

package lsh_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_START  = 2'd0;
   localparam op_type OP_TILE   = 2'd1;
   localparam op_type OP_BOT    = 2'd2;
   localparam op_type OP_FINISH = 2'd3;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 64;

   // last field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic               mark_initial;
      logic               level_won;
      logic signed [31:0] bot_data;
      logic [15:0]        bot_position;
      logic [7:0]         bot_kind;
      logic [7:0]         old_tile;
      logic [7:0]         tile;
      logic [11:0]        guy_y;
      logic [11:0]        guy_x;
   } req_data_type;

   typedef logic [3:0] cmd_type;

   localparam cmd_type CMD_IDLE    = 4'd0;
   localparam cmd_type CMD_CAPTURE = 4'd1;
   localparam cmd_type CMD_SEED    = 4'd2;
   localparam cmd_type CMD_TILE    = 4'd3;
   localparam cmd_type CMD_BOT_PRE = 4'd4;
   localparam cmd_type CMD_BOT_MID = 4'd5;
   localparam cmd_type CMD_MUL_HI  = 4'd6;
   localparam cmd_type CMD_MUL_LO  = 4'd7;
   localparam cmd_type CMD_EMIT    = 4'd8;

   typedef struct packed {
      cmd_type cmd;
      logic    sel_p3;
   } ctl_type;

   typedef struct packed {
      logic rsp_busy;
   } sts_type;

   localparam logic [63:0] HASH_SEED  = 64'h3333333333333333;
   localparam logic [63:0] NIB_HI     = 64'hF0F0F0F0F0F0F0F0;
   localparam logic [63:0] NIB_LO     = 64'h0F0F0F0F0F0F0F0F;
   localparam logic [31:0] P2_K_HI    = 32'h12345678;
   localparam logic [31:0] P2_K_LO    = 32'h09ABCDEF;
   localparam logic [63:0] P2_XOR     = 64'h00112233FFEEDDCC;
   localparam logic [63:0] P3_XOR     = 64'h1F1F2E2E3D3D4C4C;
   localparam logic [31:0] P3_K_HI    = 32'h19283746;
   localparam logic [31:0] P3_K_LO    = 32'hF9E8D7C6;
   localparam logic [63:0] WON_FLIP   = 64'hFFFF0000FFFF0000;

   function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] n);
      logic [127:0] w;
      w = {v, v} >> n;
      return w[63:0];
   endfunction

   function automatic logic [63:0] mix_p1(input logic [63:0] h);
      logic [5:0]  n;
      logic [63:0] r;
      logic [63:0] s;
      n = {1'b0, h[4:0]} + 6'd1;
      r = rotr64(h, n);
      s = ((r & NIB_HI) >> 4) | ((r & NIB_LO) << 4);
      return {s[63:32], s[15:0], s[31:16]};
   endfunction

endpackage

`default_nettype wire

### src/lsh_datapath.sv
// Hash datapath: running hash, bot count, shared 32x32 multiplier, key register.
// Depends on lsh_pkg.
`default_nettype none

module lsh_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lsh_pkg::ctl_type               ctl,
   output lsh_pkg::sts_type                    sts,
   input  wire logic [lsh_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [lsh_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import lsh_pkg::*;

   req_data_type item_ff, item_in;
   logic [63:0]  hash_ff, hash_in;
   logic [5:0]   count_ff, count_in;
   logic [63:0]  prod_ff, prod_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  key_ff, key_in;

   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;
   logic [63:0]  won_key;

   assign mul_a = (ctl.cmd == CMD_MUL_HI) ? hash_ff[63:32] : hash_ff[31:0];
   always_comb begin
      if (ctl.cmd == CMD_MUL_HI) begin
         mul_b = ctl.sel_p3 ? P3_K_HI : P2_K_HI;
      end else begin
         mul_b = ctl.sel_p3 ? P3_K_LO : P2_K_LO;
      end
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   assign won_key = (item_ff.level_won && item_ff.mark_initial) ? (hash_ff ^ WON_FLIP)
                                                                : hash_ff;

   always_comb begin
      item_in      = item_ff;
      hash_in      = hash_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (ctl.cmd)
         CMD_CAPTURE: begin
            item_in = req_data_type'(req_tdata);
         end
         CMD_SEED: begin
            hash_in  = HASH_SEED ^ ({52'd0, item_ff.guy_x} << 31) ^ {52'd0, item_ff.guy_y};
            count_in = '0;
         end
         CMD_TILE: begin
            hash_in = mix_p1(hash_ff ^ {56'd0, item_ff.tile}) + {56'd0, item_ff.old_tile};
         end
         CMD_BOT_PRE: begin
            hash_in  = rotr64(hash_ff, count_ff) ^ {56'd0, item_ff.bot_kind} ^ P3_XOR;
            count_in = count_ff + 6'd1;
         end
         CMD_BOT_MID: begin
            hash_in = mix_p1(hash_ff ^ {48'd0, item_ff.bot_position})
                      ^ {{32{item_ff.bot_data[31]}}, item_ff.bot_data};
         end
         CMD_MUL_HI: begin
            prod_in = mul_p;
         end
         CMD_MUL_LO: begin
            hash_in = (prod_ff | mul_p) ^ (ctl.sel_p3 ? 64'd0 : P2_XOR);
         end
         CMD_EMIT: begin
            key_in       = (won_key == 64'd0) ? 64'd1 : won_key;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      key_ff  <= key_in;
      if (reset) begin
         hash_ff      <= HASH_SEED;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = key_ff;

   a_key_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl.cmd == CMD_EMIT |=> rsp_tvalid && rsp_tdata != 64'd0)
      else $error("emitted key is zero");

   a_seed_clears_count: assert property (@(posedge clock) disable iff (reset)
      ctl.cmd == CMD_SEED |=> count_ff == 6'd0)
      else $error("bot count not cleared by start");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending key beat changed or dropped");

endmodule

`default_nettype wire

### src/lsh_control.sv
// Sequencer for the level state hash: steps each item through the mix rounds.
// Depends on lsh_pkg.
`default_nettype none

module lsh_control (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire lsh_pkg::op_type req_tuser,
   input  wire lsh_pkg::sts_type sts,
   output lsh_pkg::ctl_type     ctl
);
   import lsh_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEED   = 4'd1;
   localparam logic [3:0] S_TILE   = 4'd2;
   localparam logic [3:0] S_BOTPRE = 4'd3;
   localparam logic [3:0] S_P3HI   = 4'd4;
   localparam logic [3:0] S_P3LO   = 4'd5;
   localparam logic [3:0] S_BOTMID = 4'd6;
   localparam logic [3:0] S_P2HI   = 4'd7;
   localparam logic [3:0] S_P2LO   = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      ctl.cmd    = CMD_IDLE;
      ctl.sel_p3 = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.cmd = CMD_CAPTURE;
               unique case (req_tuser)
                  OP_START:  state_in = S_SEED;
                  OP_TILE:   state_in = S_TILE;
                  OP_BOT:    state_in = S_BOTPRE;
                  OP_FINISH: state_in = S_EMIT;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SEED: begin
            ctl.cmd  = CMD_SEED;
            state_in = S_P2HI;
         end
         S_TILE: begin
            ctl.cmd  = CMD_TILE;
            state_in = S_P2HI;
         end
         S_BOTPRE: begin
            ctl.cmd  = CMD_BOT_PRE;
            state_in = S_P3HI;
         end
         S_P3HI: begin
            ctl.cmd    = CMD_MUL_HI;
            ctl.sel_p3 = 1'b1;
            state_in   = S_P3LO;
         end
         S_P3LO: begin
            ctl.cmd    = CMD_MUL_LO;
            ctl.sel_p3 = 1'b1;
            state_in   = S_BOTMID;
         end
         S_BOTMID: begin
            ctl.cmd  = CMD_BOT_MID;
            state_in = S_P2HI;
         end
         S_P2HI: begin
            ctl.cmd  = CMD_MUL_HI;
            state_in = S_P2LO;
         end
         S_P2LO: begin
            ctl.cmd  = CMD_MUL_LO;
            state_in = S_IDLE;
         end
         S_EMIT: begin
            if (!sts.rsp_busy) begin
               ctl.cmd  = CMD_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctl.cmd == CMD_EMIT |-> !sts.rsp_busy)
      else $error("key written over a pending beat");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted beat not processed");

   a_p3_pairs: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_P3LO |-> $past(state_ff) == S_P3HI)
      else $error("low multiply without high multiply");

endmodule

`default_nettype wire

### src/level_state_hash64_unit.sv
// Level state hash, top level: joins the sequencer and the hash datapath.
// Depends on lsh_pkg, lsh_control and lsh_datapath.
// Each beat is taken one at a time. A start or tile beat runs its step,
// then one mix round; a bot beat runs its pre step, a mix round, its mid
// step and a mix round; a finish beat emits the key, but waits while an
// earlier key still waits on the output. Each mix round uses the single
// 32x32 multiplier twice (high half, then low half). A finish beat puts the
// key in an output register; new beats are taken while it waits to be read.
`default_nettype none

module level_state_hash64_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // guy_x, guy_y, tile, old_tile, bot_kind, bot_position, bot_data,
   // level_won, mark_initial, zero fill
   input  wire logic [lsh_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire lsh_pkg::op_type                req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // state_key
   output logic [lsh_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import lsh_pkg::*;

   ctl_type ctl;
   sts_type sts;

   lsh_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .ctl        (ctl)
   );

   lsh_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
